// ===== hdl/hst_pkg.sv =====
// Shared types, widths and constants for the half-sine tremolo core.
// No dependencies; imported by every module in hdl/.
`timescale 1ns / 1ps

package hst_pkg;

    localparam int PHASE_BITS  = 20;
    localparam int PERIOD_BITS = 20;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAME_BITS  = 2 * SAMPLE_BITS;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(22050);

    // Divider produces a Q0.16 fraction of the period.
    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Gain and quarter-wave argument, Q1.15 unsigned (0 .. 1.0).
    localparam int GAIN_BITS = 16;
    localparam int Q_SHIFT   = 15;
    localparam int P_SHIFT   = 30;
    localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(32768);
    localparam logic [FRAC_BITS:0]   FRAC_HALF  = (FRAC_BITS+1)'(32768);
    localparam logic [FRAC_BITS:0]   FRAC_ONE   = (FRAC_BITS+1)'(65536);

    // Shared multiplier operand widths.
    localparam int MUL_A_BITS = 16;
    localparam int MUL_B_BITS = 32;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    // Odd series for sin(pi/2 * u), Q2.30.
    localparam int COEF_BITS = 32;
    localparam logic [COEF_BITS-1:0] SIN_C1 = 32'd1686629713;
    localparam logic [COEF_BITS-1:0] SIN_C3 = 32'd693598669;
    localparam logic [COEF_BITS-1:0] SIN_C5 = 32'd85569306;
    localparam logic [COEF_BITS-1:0] SIN_C7 = 32'd5026995;
    localparam logic [COEF_BITS-1:0] SIN_C9 = 32'd172272;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ISSUE,
        ST_TAKE,
        ST_DELIVER
    } state_t;

    typedef enum logic [2:0] {
        OP_SQUARE,
        OP_C7,
        OP_C5,
        OP_C3,
        OP_C1,
        OP_GAIN,
        OP_LEFT,
        OP_RIGHT
    } op_t;

    function automatic logic [COEF_BITS-1:0] coef_of(input op_t op);
        logic [COEF_BITS-1:0] c;
        unique case (op)
            OP_C7:   c = SIN_C7;
            OP_C5:   c = SIN_C5;
            OP_C3:   c = SIN_C3;
            OP_C1:   c = SIN_C1;
            default: c = SIN_C1;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/hst_div.sv =====
// Restoring divider: floor(dividend * 2^16 / divisor), one quotient bit a cycle.
// Depends on hst_pkg. Requires dividend < divisor.
`timescale 1ns / 1ps

module hst_div
    import hst_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [PERIOD_BITS-1:0] dividend,
    input  logic [PERIOD_BITS-1:0] divisor,
    output logic                   done,
    output logic [FRAC_BITS-1:0]   quotient
);

    logic [PERIOD_BITS-1:0]  rem_reg, rem_next;
    logic [PERIOD_BITS-1:0]  dvs_reg, dvs_next;
    logic [FRAC_BITS-1:0]    quo_reg, quo_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic [PERIOD_BITS:0] rem_shift;
    logic [PERIOD_BITS:0] rem_diff;
    logic                 fits;

    always_comb begin
        rem_shift = {rem_reg, 1'b0};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
    end

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dvs_next  = divisor;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? rem_diff[PERIOD_BITS-1:0] : rem_shift[PERIOD_BITS-1:0];
            quo_next = {quo_reg[FRAC_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/hst_mul.sv =====
// Shared unsigned multiplier with a registered product, used for every
// multiply of the gain and scaling sequence. Depends on hst_pkg.
`timescale 1ns / 1ps

module hst_mul
    import hst_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic [MUL_A_BITS-1:0] op_a,
    input  logic [MUL_B_BITS-1:0] op_b,
    output logic [PROD_BITS-1:0]  prod
);

    logic [PROD_BITS-1:0] prod_reg, prod_next;

    always_comb begin
        prod_next = prod_reg;
        if (en) begin
            prod_next = PROD_BITS'(op_a) * PROD_BITS'(op_b);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/half_sine_tremolo_core.sv =====
// Half-sine tremolo: each stereo word is scaled by sin(pi * phase / period).
// A frame passes through the bit-per-cycle divider that forms phase/period
// (16 quotient bits, then a registered done flag), then eight multiplies on
// the one shared multiplier, each issued in ST_ISSUE and taken in ST_TAKE
// (sine polynomial, then left and right samples), plus a state each to accept
// (ST_IDLE) and to deliver (ST_DELIVER). s_tready is high only between
// frames; a finished word waits in the output register
// while the next frame is taken in. The period register may be written only
// while no frame is in flight; a period of zero acts as one.
// Depends on hst_pkg, hst_div and hst_mul.
`timescale 1ns / 1ps

module half_sine_tremolo_core
    import hst_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [PERIOD_BITS-1:0] cfg_wdata,   // period_samples
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [FRAME_BITS-1:0]  s_tdata,     // sample_left, sample_right
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [FRAME_BITS-1:0]  m_tdata      // out_left, out_right
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [PERIOD_BITS-1:0] period_reg, period_next;
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [FRAME_BITS-1:0]  m_tdata_reg;

    logic [SAMPLE_BITS-1:0] left_reg, right_reg;
    logic [SAMPLE_BITS-1:0] out_l_reg, out_r_reg;
    logic [GAIN_BITS-1:0]   t_reg, u2_reg, g_reg;
    logic [COEF_BITS-1:0]   p_reg;

    // FSM outputs
    logic accept, div_start, mul_en, take, deliver;

    logic [PERIOD_BITS-1:0] period_eff, phase_eff;
    logic [PERIOD_BITS:0]   phase_inc;
    logic                   div_done;
    logic [FRAC_BITS-1:0]   div_quo;
    logic [FRAC_BITS:0]     quarter;
    logic [MUL_A_BITS-1:0]  mul_a;
    logic [MUL_B_BITS-1:0]  mul_b;
    logic [PROD_BITS-1:0]   prod;
    logic [GAIN_BITS:0]     gain_raw;
    logic [SAMPLE_BITS:0]   scaled;
    logic [SAMPLE_BITS-1:0] mag_l, mag_r;

    function automatic logic [SAMPLE_BITS-1:0] apply_sign(
        input logic neg, input logic [SAMPLE_BITS:0] r);
        logic [SAMPLE_BITS:0]   smax;
        logic [SAMPLE_BITS:0]   neg_r;
        logic [SAMPLE_BITS-1:0] res;
        smax  = {2'b00, {(SAMPLE_BITS-1){1'b1}}};
        neg_r = ~r + 1'b1;
        if (!neg) begin
            res = (r > smax) ? smax[SAMPLE_BITS-1:0] : r[SAMPLE_BITS-1:0];
        end else begin
            res = (r > smax + 1'b1) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                    : neg_r[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    // Effective period and phase
    always_comb begin
        period_eff = (period_reg == '0) ? PERIOD_BITS'(1) : period_reg;
        phase_eff  = (PERIOD_BITS'(phase_reg) >= period_eff) ? '0 : PERIOD_BITS'(phase_reg);
        phase_inc  = {1'b0, phase_eff} + 1'b1;
    end

    hst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (phase_eff),
        .divisor  (period_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Fold to a quarter wave
    assign quarter = ({1'b0, div_quo} <= FRAC_HALF) ? {1'b0, div_quo}
                                                    : FRAC_ONE - {1'b0, div_quo};

    assign mag_l = left_reg[SAMPLE_BITS-1]  ? (~left_reg + 1'b1)  : left_reg;
    assign mag_r = right_reg[SAMPLE_BITS-1] ? (~right_reg + 1'b1) : right_reg;

    // Operand select for the shared multiplier
    always_comb begin
        unique case (op_reg)
            OP_SQUARE: begin
                mul_a = MUL_A_BITS'(t_reg);
                mul_b = MUL_B_BITS'(t_reg);
            end
            OP_C7, OP_C5, OP_C3, OP_C1: begin
                mul_a = MUL_A_BITS'(u2_reg);
                mul_b = MUL_B_BITS'(p_reg);
            end
            OP_GAIN: begin
                mul_a = MUL_A_BITS'(t_reg);
                mul_b = MUL_B_BITS'(p_reg);
            end
            OP_LEFT: begin
                mul_a = MUL_A_BITS'(mag_l);
                mul_b = MUL_B_BITS'(g_reg);
            end
            OP_RIGHT: begin
                mul_a = MUL_A_BITS'(mag_r);
                mul_b = MUL_B_BITS'(g_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    hst_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign gain_raw = prod[P_SHIFT +: GAIN_BITS+1];
    assign scaled   = prod[Q_SHIFT +: SAMPLE_BITS+1];

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_DIVIDE;
            ST_DIVIDE:  if (div_done) state_next = ST_ISSUE;
            ST_ISSUE:   state_next = ST_TAKE;
            ST_TAKE:    state_next = (op_reg == OP_RIGHT) ? ST_DELIVER : ST_ISSUE;
            ST_DELIVER: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        mul_en    = 1'b0;
        take      = 1'b0;
        deliver   = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_DIVIDE:  ;
            ST_ISSUE:   mul_en = 1'b1;
            ST_TAKE:    take = 1'b1;
            ST_DELIVER: deliver = !m_tvalid_reg || m_tready;
            default:    ;
        endcase
        accept    = s_tready && s_tvalid;
        div_start = accept;
    end

    // Control registers
    always_comb begin
        period_next = cfg_we ? cfg_wdata : period_reg;
        phase_next  = phase_reg;
        if (accept) begin
            phase_next = (phase_inc >= {1'b0, period_eff}) ? '0 : PHASE_BITS'(phase_inc);
        end
        op_next = op_reg;
        if (div_done) begin
            op_next = OP_SQUARE;
        end else if (take && op_reg != OP_RIGHT) begin
            op_next = op_t'(op_reg + 1'b1);
        end
        m_tvalid_next = deliver ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_SQUARE;
            period_reg   <= PERIOD_RESET;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            period_reg   <= period_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            left_reg  <= s_tdata[0 +: SAMPLE_BITS];
            right_reg <= s_tdata[SAMPLE_BITS +: SAMPLE_BITS];
        end
        if (div_done) begin
            t_reg <= quarter[GAIN_BITS-1:0];
            p_reg <= SIN_C9;
        end
        if (take) begin
            unique case (op_reg)
                OP_SQUARE: u2_reg <= prod[Q_SHIFT +: GAIN_BITS];
                OP_C7, OP_C5, OP_C3, OP_C1:
                    p_reg <= coef_of(op_reg) - prod[Q_SHIFT +: COEF_BITS];
                OP_GAIN:
                    g_reg <= (gain_raw > {1'b0, GAIN_UNITY}) ? GAIN_UNITY
                                                             : gain_raw[GAIN_BITS-1:0];
                OP_LEFT:   out_l_reg <= apply_sign(left_reg[SAMPLE_BITS-1], scaled);
                OP_RIGHT:  out_r_reg <= apply_sign(right_reg[SAMPLE_BITS-1], scaled);
                default:   ;
            endcase
        end
        if (deliver) begin
            m_tdata_reg <= {out_r_reg, out_l_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== test/hst_gain_monitor.sv =====
// Watches both streams of the half-sine tremolo core, predicts every output word
// from the input words and the period writes, and compares field by field.
// Depends on hst_pkg for widths; instantiated beside the core by testbench.
`timescale 1ns / 1ps

module hst_gain_monitor
    import hst_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [PERIOD_BITS-1:0] cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [FRAME_BITS-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [FRAME_BITS-1:0]  m_tdata,
    output int                     frames_due,
    output int                     mismatches
);

    // odd series for sin(pi/2 * u), Q2.30
    localparam logic [63:0] K1 = 64'd1686629713;
    localparam logic [63:0] K3 = 64'd693598669;
    localparam logic [63:0] K5 = 64'd85569306;
    localparam logic [63:0] K7 = 64'd5026995;
    localparam logic [63:0] K9 = 64'd172272;
    localparam logic [63:0] UNITY = 64'd32768;

    // index 0 is the left sample, index 1 the right one
    typedef logic [1:0][SAMPLE_BITS-1:0] stereo_t;

    stereo_t                scaled_due[$];
    logic [PERIOD_BITS-1:0] period_reg;
    logic [PHASE_BITS-1:0]  phase_pos;
    int                     err_total;
    int                     word_count;

    function automatic logic [63:0] half_sine_gain(input logic [63:0] ph, input logic [63:0] per);
        logic [63:0] x, t, u2, p, g;
        x  = (ph << 16) / per;
        t  = (x <= UNITY) ? x : (64'd65536 - x);
        u2 = (t * t) >> 15;
        p  = K9;
        p  = K7 - ((u2 * p) >> 15);
        p  = K5 - ((u2 * p) >> 15);
        p  = K3 - ((u2 * p) >> 15);
        p  = K1 - ((u2 * p) >> 15);
        g  = (t * p) >> 30;
        return (g > UNITY) ? UNITY : g;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] apply_gain(input logic signed [SAMPLE_BITS-1:0] s,
                                                          input logic [63:0] g);
        longint sv, gv, r;
        sv = s;
        gv = longint'(g);
        // truncate toward zero: scale the magnitude, then restore the sign
        if (sv < 0)
            r = -(((-sv) * gv) / 32768);
        else
            r = (sv * gv) / 32768;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [63:0] per, ph, g;
        stereo_t     in_word, want, got;
        if (!aresetn) begin
            period_reg = PERIOD_BITS'(22050);
            phase_pos  = '0;
            scaled_due.delete();
            err_total  = 0;
            word_count = 0;
        end else begin
            if (cfg_we)
                period_reg = cfg_wdata;
            if (s_tvalid && s_tready) begin
                in_word = s_tdata;
                per = (period_reg == '0) ? 64'd1 : 64'(period_reg);
                ph  = 64'(phase_pos);
                // phase left past a lowered period restarts the cycle
                if (ph >= per)
                    ph = 0;
                g = half_sine_gain(ph, per);
                want[0] = apply_gain(in_word[0], g);
                want[1] = apply_gain(in_word[1], g);
                scaled_due.push_back(want);
                ph = ph + 1;
                if (ph >= per)
                    ph = 0;
                phase_pos = ph[PHASE_BITS-1:0];
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (scaled_due.size() == 0) begin
                    err_total++;
                    if (err_total <= 10)
                        $display("output word %0d arrived with no input pending: L=%0d R=%0d",
                                 word_count, $signed(got[0]), $signed(got[1]));
                end else begin
                    want = scaled_due.pop_front();
                    for (int f = 0; f < 2; f++) begin
                        if (got[f] !== want[f]) begin
                            err_total++;
                            if (err_total <= 10)
                                $display("word %0d %s: expected %0d, got %0d", word_count,
                                         (f == 0) ? "left" : "right",
                                         $signed(want[f]), $signed(got[f]));
                        end
                    end
                end
                word_count++;
            end
        end
        frames_due <= scaled_due.size();
        mismatches <= err_total;
    end

endmodule

// ===== test/testbench.sv =====
// Top of the tremolo core test: clock, reset, stream and period stimulus,
// and the verdict. Depends on hst_pkg, half_sine_tremolo_core, hst_gain_monitor.
`timescale 1ns / 1ps

module testbench
    import hst_pkg::*;
();

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_PHASES = 12;
    localparam int WORDS_PER_PHASE = 56;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [PERIOD_BITS-1:0] cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [FRAME_BITS-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [FRAME_BITS-1:0]  m_tdata;
    int                     frames_due;
    int                     mismatches;

    logic calm;
    logic hold_req;
    int   hold_count;
    int   quiet_cycles;

    half_sine_tremolo_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    hst_gain_monitor u_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .frames_due (frames_due),
        .mismatches (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver: random stalls, one long hold-off on request, none while calm
    initial begin
        m_tready <= 1'b0;
        hold_count = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && hold_count < HOLD_CYCLES) begin
                m_tready <= 1'b0;
                hold_count++;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 26);
            end
        end
    end

    // no handshake on either side for too long ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] v;
        case ($urandom_range(11))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'hFFFF;
            3:       v = 16'h0001;
            default: v = SAMPLE_BITS'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic [PERIOD_BITS-1:0] pick_period();
        int r;
        logic [PERIOD_BITS-1:0] p;
        r = $urandom_range(99);
        if (r < 55)
            p = PERIOD_BITS'($urandom_range(80, 2));
        else if (r < 75)
            p = PERIOD_BITS'($urandom_range(5000, 81));
        else if (r < 93)
            p = PERIOD_BITS'($urandom());
        else
            p = PERIOD_BITS'($urandom_range(1));
        return p;
    endfunction

    // offer one word; tvalid stays high afterwards so back-to-back words need no dip
    task automatic send_frame(input logic [SAMPLE_BITS-1:0] left, input logic [SAMPLE_BITS-1:0] right);
        while (!calm && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // stop sending, let every word drain, then write the period
    task automatic set_period(input logic [PERIOD_BITS-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frames_due != 0)
            @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        calm      <= 1'b0;
        hold_req  <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default period: gain near zero
        send_frame(16'h7FFF, 16'h8000);
        send_frame(16'h8000, 16'h7FFF);
        send_frame(16'h0000, 16'hFFFF);
        send_frame(16'h4000, 16'hC000);

        // short period wraps quickly and hits full gain at phase 2
        set_period(20'd4);
        send_frame(16'h7FFF, 16'h8000);
        send_frame(16'h8000, 16'h7FFF);
        send_frame(16'h7FFF, 16'h8000);
        send_frame(16'hFFFF, 16'h0001);
        send_frame(16'h5555, 16'hAAAA);
        send_frame(16'hAAAA, 16'h5555);

        // longest period, then drop it below the phase reached
        set_period(20'hFFFFF);
        repeat (8) send_frame(pick_sample(), pick_sample());
        set_period(20'd5);
        repeat (3) send_frame(pick_sample(), pick_sample());

        // zero period behaves as one
        set_period(20'd0);
        repeat (3) send_frame(16'h7FFF, 16'h8000);
        set_period(20'd1);
        repeat (2) send_frame(16'h8000, 16'h7FFF);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_period(pick_period());
            calm <= (ph == 5);
            if (ph == 2)
                hold_req <= 1'b1;
            repeat (WORDS_PER_PHASE) send_frame(pick_sample(), pick_sample());
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frames_due != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/hst_pkg.sv
hdl/hst_div.sv
hdl/hst_mul.sv
hdl/half_sine_tremolo_core.sv
test/hst_gain_monitor.sv
test/testbench.sv
